/* rtl/core/grb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types, codes and helpers of the glyph row blitter.
// ----------------------------------------------------------------------------
package grb_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic REG_GLYPH_ROWS = 1'b0;
	localparam logic REG_FRAME_BASE = 1'b1;

	localparam logic [1:0] SCALE_1X = 2'd0;
	localparam logic [1:0] SCALE_2X = 2'd1;
	localparam logic [1:0] SCALE_4X = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic        is_load;
		logic [11:0] store_addr;
		logic [7:0]  font_byte;
		logic [24:0] start_addr;
		logic [8:0]  y_pos;
		logic [15:0] color;
		logic [1:0]  scale_sel;
		logic [4:0]  rows;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// repeat each glyph bit 1, 2 or 4 times, MSB leftmost
	function automatic logic [31:0] widen_row(logic [7:0] bits, logic [1:0] sel);
		logic [31:0] m;
		logic [4:0]  src;
		logic [1:0]  sh;
		m  = '0;
		sh = (sel == SCALE_1X) ? 2'd0 : (sel == SCALE_2X) ? 2'd1 : 2'd2;
		for (int i = 0; i < 32; i++) begin
			src  = 5'(i) >> sh;
			m[i] = (src < 5'd8) ? bits[3'(5'd7 - src)] : 1'b0;
		end
		return m;
	endfunction

	function automatic logic [1:0] scale_last(logic [1:0] sel);
		logic [1:0] r;
		unique case (sel)
			SCALE_1X: r = 2'd0;
			SCALE_2X: r = 2'd1;
			default:  r = 2'd3;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/glyph_row_blitter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_row_blitter
// 8-pixel bitmap font character generator with 1x/2x/4x replication.
// Path of a draw: intake register, command queue, font store read register, output register.
// A draw holds the line sequencer until all its lines are written, one line write
// per cycle from the font store read port while the output is not stalled; a load only writes the store.
// Reset clears control state, sets glyph rows to 8; font store undefined until loaded.
// ----------------------------------------------------------------------------
module glyph_row_blitter #(
	parameter int LINE_PITCH     = 640,
	parameter int FRAME_LINES    = 480,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [7:0]  char_code,
	input  wire  [3:0]  glyph_row,
	input  wire  [7:0]  font_byte,
	input  wire  [9:0]  x_pos,
	input  wire  [8:0]  y_pos,
	input  wire  [15:0] color,
	input  wire  [1:0]  scale_sel,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [24:0] row_address,
	output logic [31:0] pixel_mask,
	output logic [15:0] pixel_color,
	output logic        off_frame,
	output logic        last
);

	logic               push;
	logic               pop;
	grb_pkg::cmd_t      push_cmd;
	grb_pkg::cmd_t      head_cmd;
	grb_pkg::q_status_t q_status;

	grb_front #(
		.LINE_PITCH     (LINE_PITCH),
		.MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.char_code (char_code),
		.glyph_row (glyph_row),
		.font_byte (font_byte),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.color     (color),
		.scale_sel (scale_sel),
		.push      (push),
		.cmd       (push_cmd),
		.q_status  (q_status)
	);

	grb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_status (q_status)
	);

	grb_back #(
		.LINE_PITCH     (LINE_PITCH),
		.FRAME_LINES    (FRAME_LINES),
		.MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_cmd    (head_cmd),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_address (row_address),
		.pixel_mask  (pixel_mask),
		.pixel_color (pixel_color),
		.off_frame   (off_frame),
		.last        (last)
	);

endmodule
`default_nettype wire

/* rtl/core/grb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grb_front
// Config registers, item intake, classification and address setup.
// ----------------------------------------------------------------------------
module grb_front #(
	parameter int LINE_PITCH     = 640,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [2:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               op,
	input  wire  [7:0]        char_code,
	input  wire  [3:0]        glyph_row,
	input  wire  [7:0]        font_byte,
	input  wire  [9:0]        x_pos,
	input  wire  [8:0]        y_pos,
	input  wire  [15:0]       color,
	input  wire  [1:0]        scale_sel,
	output logic              push,
	output grb_pkg::cmd_t     cmd,
	input  wire grb_pkg::q_status_t q_status
);

	logic [4:0]    glyph_rows_q;
	logic [23:0]   frame_base_q;
	logic          valid_s1;
	grb_pkg::cmd_t cmd_s1;
	grb_pkg::cmd_t cmd_new;
	logic [4:0]    rows_clamp;
	logic          keep;
	logic          accept;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == grb_pkg::REG_FRAME_BASE) ? 32'(frame_base_q)
	                                                      : 32'(glyph_rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_rows_q <= 5'd8;
			frame_base_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == grb_pkg::REG_FRAME_BASE) begin
				frame_base_q <= pwdata[23:0];
			end else begin
				glyph_rows_q <= pwdata[4:0];
			end
		end
	end

	assign rows_clamp = (glyph_rows_q > 5'(MAX_GLYPH_ROWS)) ? 5'(MAX_GLYPH_ROWS) : glyph_rows_q;

	always_comb begin
		cmd_new.is_load    = (op == grb_pkg::OP_LOAD);
		cmd_new.store_addr = 12'(12'(char_code) * 12'(MAX_GLYPH_ROWS))
		                   + ((op == grb_pkg::OP_LOAD) ? 12'(glyph_row) : 12'd0);
		cmd_new.font_byte  = font_byte;
		cmd_new.start_addr = 25'(25'(frame_base_q) + 25'(y_pos) * 25'(LINE_PITCH) + 25'(x_pos));
		cmd_new.y_pos      = y_pos;
		cmd_new.color      = color;
		cmd_new.scale_sel  = (scale_sel == 2'd3) ? grb_pkg::SCALE_4X : scale_sel;
		cmd_new.rows       = rows_clamp;
		keep = (op == grb_pkg::OP_LOAD) ? ({1'b0, glyph_row} < 5'(MAX_GLYPH_ROWS))
		                                : (rows_clamp != 5'd0);
	end

	assign in_stall = valid_s1 && q_status.full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_status.full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/grb_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module grb_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire grb_pkg::cmd_t push_cmd,
	input  wire                pop,
	output grb_pkg::cmd_t      head_cmd,
	output grb_pkg::q_status_t q_status
);

	grb_pkg::cmd_t              slots_q [grb_pkg::QDEPTH];
	logic [grb_pkg::QPTR_W-1:0] wptr_q;
	logic [grb_pkg::QPTR_W-1:0] rptr_q;
	logic [grb_pkg::QPTR_W:0]   count_q;

	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == (grb_pkg::QPTR_W+1)'(grb_pkg::QDEPTH));
	assign head_cmd       = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/grb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grb_back
// Font store and line sequencer: one framebuffer line write per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module grb_back #(
	parameter int LINE_PITCH     = 640,
	parameter int FRAME_LINES    = 480,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire grb_pkg::cmd_t head_cmd,
	input  wire grb_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [24:0]        row_address,
	output logic [31:0]        pixel_mask,
	output logic [15:0]        pixel_color,
	output logic               off_frame,
	output logic               last
);

	localparam int DEPTH = 256 * MAX_GLYPH_ROWS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic [7:0]  store_q [DEPTH];
	logic [7:0]  rdata_q;
	logic        state_q;
	logic [11:0] base_q;
	logic [24:0] addr_q;
	logic [12:0] y_q;
	logic [15:0] color_q;
	logic [1:0]  sel_q;
	logic [1:0]  sub_last_q;
	logic [4:0]  rows_q;
	logic [4:0]  row_q;
	logic [1:0]  sub_q;
	logic        ov_q;

	logic        out_free;
	logic        emit;
	logic        row_end;
	logic        draw_end;
	logic        rd_en;
	logic [11:0] rd_addr;
	logic        wr_en;

	assign out_free = !ov_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign row_end  = (sub_q == sub_last_q);
	assign draw_end = row_end && (row_q == rows_q - 5'd1);
	assign wr_en    = pop && head_cmd.is_load;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_cmd.store_addr;
		if (pop && !head_cmd.is_load) begin
			rd_en = 1'b1;
		end else if (emit && row_end && !draw_end) begin
			rd_en   = 1'b1;
			rd_addr = base_q + 12'(row_q) + 12'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[head_cmd.store_addr[AW-1:0]] <= head_cmd.font_byte;
		end
		if (rd_en) begin
			rdata_q <= store_q[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			sub_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !head_cmd.is_load) begin
						state_q <= ST_EMIT;
						row_q   <= '0;
						sub_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (draw_end) begin
							state_q <= ST_IDLE;
						end
						if (row_end) begin
							sub_q <= '0;
							row_q <= row_q + 5'd1;
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head_cmd.is_load) begin
			base_q     <= head_cmd.store_addr;
			addr_q     <= head_cmd.start_addr;
			y_q        <= 13'(head_cmd.y_pos);
			color_q    <= head_cmd.color;
			sel_q      <= head_cmd.scale_sel;
			sub_last_q <= grb_pkg::scale_last(head_cmd.scale_sel);
			rows_q     <= head_cmd.rows;
		end else if (emit) begin
			addr_q <= 25'(addr_q + 25'(LINE_PITCH));
			y_q    <= y_q + 13'd1;
		end
		if (emit) begin
			row_address <= addr_q;
			pixel_mask  <= grb_pkg::widen_row(rdata_q, sel_q);
			pixel_color <= color_q;
			off_frame   <= (y_q >= 13'(FRAME_LINES));
			last        <= draw_end;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire
